// ===== rtl/csam_pkg.sv =====
// csam_pkg: shared types, widths and codes of the current steering amplitude map.
// No dependencies. Used by every other file in rtl/.
`default_nettype none

package csam_pkg;

  localparam int NUM_CHANNELS_DEF   = 15;
  localparam int NUM_ELECTRODES_DEF = 16;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 4;
  localparam int SMP_W   = 16;
  localparam int COEF_W  = 24;
  localparam int AMP_W   = 20;
  localparam int WIDX_W  = 5;
  localparam int MODE_W  = 2;
  localparam int PROD_W  = AMP_W + SMP_W;

  // register stages per lane, table read included
  localparam int NSTG = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_MAP  = 2'd0,
    REQ_ELEC = 2'd1,
    REQ_CHAN = 2'd2
  } req_e;

  typedef enum logic [MODE_W-1:0] {
    CM_NONE = 2'd0,
    CM_ENV  = 2'd1,
    CM_ALL  = 2'd2
  } cmode_e;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         index;
    logic [SMP_W-1:0]         envelope;
    logic [SMP_W-1:0]         carrier_sample;
    logic [SMP_W-1:0]         weight_low;
    logic [SMP_W-1:0]         weight_high;
    logic signed [COEF_W-1:0] entry_gain;
    logic signed [COEF_W-1:0] entry_offset;
    logic [AMP_W-1:0]         entry_clip;
    logic [IDX_W-1:0]         entry_electrode;
    logic                     frame_last;
  } in_word_t;

  typedef struct packed {
    logic [WIDX_W-1:0] word_index_low;
    logic [AMP_W-1:0]  amplitude_low;
    logic [WIDX_W-1:0] word_index_high;
    logic [AMP_W-1:0]  amplitude_high;
    logic              last_out;
  } out_word_t;

  // one electrode table entry
  typedef struct packed {
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] offset;
    logic [AMP_W-1:0]         clip;
  } ent_t;

  // per-word side info carried next to the lanes
  typedef struct packed {
    logic [WIDX_W-1:0] widx;
    logic              last;
  } meta_t;

  // stage enables and carrier mode, fanned out to the lanes
  typedef struct packed {
    logic [NSTG-1:0]   en;
    logic [MODE_W-1:0] mode;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/csam_in_if.sv =====
// csam_in_if: valid/ready channel carrying one input word.
// Depends on csam_pkg.
`default_nettype none

interface csam_in_if import csam_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/csam_out_if.sv =====
// csam_out_if: valid/ready channel carrying one result word.
// Depends on csam_pkg.
`default_nettype none

interface csam_out_if import csam_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/current_steering_amplitude_map.sv =====
// current_steering_amplitude_map: top level, request decode, channel map, stage control.
// Depends on csam_pkg, csam_in_if, csam_out_if, csam_etab, csam_lane, csam_merge.
//
// One word per clock in while in_i.ready is high, one result word per map request
// out. A map request (req_type 0, channel in range) looks up its low electrode L in
// the channel map and reads both electrode entries L and L+1 in the same cycle; two
// lanes, one per electrode, then form gain*env+offset with the selected carrier
// mode, clamp to [0, clip] and apply the steering weight. The merge stage saturates
// both amplitudes and holds the result word, fed by the last of five lane stages.
// Throughput is one word per cycle while the output is not stalled, set by the lane
// multipliers which each sit in a stage of their own (gain*env, carrier product,
// weight product). Table writes (req_type 1 and 2) take effect at the accept edge
// and are seen by the very next word; they give no result. The input stays ready
// while any pipeline stage has room, so a held result does not block input until
// all stages are full; with the result register empty, ready is always high. The
// electrode table reads zero after reset through per-entry valid bits and the
// channel map resets to zero, so no clearing pass is needed. The user must write
// carrier_mode via cfg_we_i/cfg_wdata_i only while no word is in flight; the block
// itself does not enforce it.
`default_nettype none

module current_steering_amplitude_map import csam_pkg::*; #(
  parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF,
  parameter int NUM_ELECTRODES = NUM_ELECTRODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  csam_in_if.sink           in_i,
  csam_out_if.source        out_o
);

  localparam int EW = $clog2(NUM_ELECTRODES);
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  in_word_t          d;
  logic              acc;
  logic              ch_ok, el_ok, map_go;
  logic [CW-1:0]     ch_sel;
  logic [EW-1:0]     el_sel, e_sat, lo, hi;
  logic [MODE_W-1:0] mode_q;
  logic [EW-1:0]     chan_q [NUM_CHANNELS];

  // stage control: v_q[i] marks a live word in stage i, ld[i] lets it load
  logic [NSTG-1:0]   v_q, ld;
  logic              cap;
  meta_t             meta_q [NSTG];
  pipe_ctl_t         ctl;

  ent_t              ent_lo, ent_hi;
  logic [PROD_W-1:0] prod_lo, prod_hi;

  assign d   = in_i.data;
  assign acc = in_i.valid & in_i.ready;

  // index range checks, widened so a 16-entry bound still compares
  assign ch_ok  = {1'b0, d.index} < (IDX_W+1)'(NUM_CHANNELS);
  assign el_ok  = {1'b0, d.index} < (IDX_W+1)'(NUM_ELECTRODES);
  assign ch_sel = ch_ok ? d.index[CW-1:0] : '0;
  assign el_sel = el_ok ? d.index[EW-1:0] : '0;
  assign map_go = (d.req_type == REQ_MAP) && ch_ok;

  // low electrode saturates so that L+1 stays a real electrode
  assign e_sat = ({1'b0, d.entry_electrode} > (IDX_W+1)'(NUM_ELECTRODES - 2))
               ? EW'(NUM_ELECTRODES - 2) : d.entry_electrode[EW-1:0];

  assign lo = chan_q[ch_sel];
  assign hi = lo + EW'(1);

  // carrier mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CM_NONE;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // channel to low-electrode map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else if (acc && (d.req_type == REQ_CHAN) && ch_ok) begin
      chan_q[ch_sel] <= e_sat;
    end
  end

  // load chain: a stage loads when empty or when the one after it loads
  always_comb begin
    ld[NSTG-1] = ~v_q[NSTG-1] | cap;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ld[i] = ~v_q[i] | ld[i+1];
    end
  end

  assign in_i.ready = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= acc & map_go;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ld[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // slot index and last flag ride alongside the lanes
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      meta_q[0].widx <= WIDX_W'({lo, 1'b0});
      meta_q[0].last <= d.frame_last;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (ld[i]) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  assign ctl.en   = ld;
  assign ctl.mode = mode_q;

  csam_etab #(
    .NUM_ELECTRODES (NUM_ELECTRODES)
  ) u_etab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (acc && (d.req_type == REQ_ELEC) && el_ok),
    .waddr_i    (el_sel),
    .wdata_i    (ent_t'{gain: d.entry_gain, offset: d.entry_offset, clip: d.entry_clip}),
    .rd_en_i    (ld[0]),
    .raddr_lo_i (lo),
    .raddr_hi_i (hi),
    .rd_lo_o    (ent_lo),
    .rd_hi_o    (ent_hi)
  );

  csam_lane u_lane_lo (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .ent_i  (ent_lo),
    .env_i  (d.envelope),
    .car_i  (d.carrier_sample),
    .w_i    (d.weight_low),
    .prod_o (prod_lo)
  );

  csam_lane u_lane_hi (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .ent_i  (ent_hi),
    .env_i  (d.envelope),
    .car_i  (d.carrier_sample),
    .w_i    (d.weight_high),
    .prod_o (prod_hi)
  );

  csam_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (v_q[NSTG-1]),
    .prod_lo_i (prod_lo),
    .prod_hi_i (prod_hi),
    .meta_i    (meta_q[NSTG-1]),
    .cap_o     (cap),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/csam_etab.sv =====
// csam_etab: electrode table (gain, offset, clip), one write port, two registered reads.
// Depends on csam_pkg.
`default_nettype none

module csam_etab import csam_pkg::*; #(
  parameter int NUM_ELECTRODES = NUM_ELECTRODES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [$clog2(NUM_ELECTRODES)-1:0] waddr_i,
  input  ent_t                              wdata_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(NUM_ELECTRODES)-1:0] raddr_lo_i,
  input  logic [$clog2(NUM_ELECTRODES)-1:0] raddr_hi_i,
  output ent_t                              rd_lo_o,
  output ent_t                              rd_hi_o
);

  ent_t                      mem [NUM_ELECTRODES];
  ent_t                      rd_lo_q, rd_hi_q;
  logic [NUM_ELECTRODES-1:0] vld_q;
  logic                      rv_lo_q, rv_hi_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rd_lo_q <= mem[raddr_lo_i];
      rd_hi_q <= mem[raddr_hi_i];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rv_lo_q <= 1'b0;
      rv_hi_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rv_lo_q <= vld_q[raddr_lo_i];
        rv_hi_q <= vld_q[raddr_hi_i];
      end
    end
  end

  assign rd_lo_o = rv_lo_q ? rd_lo_q : '0;
  assign rd_hi_o = rv_hi_q ? rd_hi_q : '0;

endmodule

`default_nettype wire

// ===== rtl/csam_lane.sv =====
// csam_lane: per-electrode mapping pipeline, gain/offset/carrier, clamp, weight product.
// Depends on csam_pkg. Table entry arrives already registered from csam_etab.
`default_nettype none

module csam_lane import csam_pkg::*; (
  input  logic              clk_i,
  input  pipe_ctl_t         ctl_i,
  input  ent_t              ent_i,
  input  logic [SMP_W-1:0]  env_i,
  input  logic [SMP_W-1:0]  car_i,
  input  logic [SMP_W-1:0]  w_i,
  output logic [PROD_W-1:0] prod_o
);

  // stage 1
  logic [SMP_W-1:0]         env1_q, car1_q, w1_q;
  // stage 2
  logic signed [40:0]       p2_q;
  logic signed [COEF_W-1:0] k2_q;
  logic [AMP_W-1:0]         clip2_q;
  logic [SMP_W-1:0]         car2_q, w2_q;
  // stage 3
  logic signed [43:0]       p3_q;
  logic signed [26:0]       sum3_q;
  logic signed [COEF_W-1:0] k3_q;
  logic [AMP_W-1:0]         clip3_q;
  logic [SMP_W-1:0]         w3_q;
  // stage 4
  logic [AMP_W-1:0]         m4_q;
  logic [SMP_W-1:0]         w4_q;
  // stage 5
  logic [PROD_W-1:0]        a5_q;

  logic signed [25:0] term;
  logic signed [26:0] sum, opa;
  logic signed [29:0] m_full;
  logic [AMP_W-1:0]   m_clamp;

  // floor(g*env / 2^15)
  assign term = $signed(p2_q[40:15]);
  assign sum  = 27'(term) + 27'(k2_q);
  assign opa  = (ctl_i.mode == CM_ALL) ? sum : 27'(term);

  always_comb begin
    case (ctl_i.mode)
      CM_ENV:  m_full = 30'($signed(p3_q[43:15])) + 30'(k3_q);
      CM_ALL:  m_full = 30'($signed(p3_q[43:15]));
      default: m_full = 30'(sum3_q);
    endcase
    if (m_full < 30'sd0) begin
      m_clamp = '0;
    end else if (m_full > $signed(30'(clip3_q))) begin
      m_clamp = clip3_q;
    end else begin
      m_clamp = m_full[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      env1_q <= env_i;
      car1_q <= car_i;
      w1_q   <= w_i;
    end
    if (ctl_i.en[1]) begin
      p2_q    <= ent_i.gain * $signed({1'b0, env1_q});
      k2_q    <= ent_i.offset;
      clip2_q <= ent_i.clip;
      car2_q  <= car1_q;
      w2_q    <= w1_q;
    end
    if (ctl_i.en[2]) begin
      p3_q    <= opa * $signed({1'b0, car2_q});
      sum3_q  <= sum;
      k3_q    <= k2_q;
      clip3_q <= clip2_q;
      w3_q    <= w2_q;
    end
    if (ctl_i.en[3]) begin
      m4_q <= m_clamp;
      w4_q <= w3_q;
    end
    if (ctl_i.en[4]) begin
      a5_q <= PROD_W'(m4_q) * PROD_W'(w4_q);
    end
  end

  assign prod_o = a5_q;

endmodule

`default_nettype wire

// ===== rtl/csam_merge.sv =====
// csam_merge: joins both lanes, saturates the weighted amplitudes, holds the result word.
// Depends on csam_pkg and csam_out_if.
`default_nettype none

module csam_merge import csam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [PROD_W-1:0] prod_lo_i,
  input  logic [PROD_W-1:0] prod_hi_i,
  input  meta_t             meta_i,
  output logic              cap_o,
  csam_out_if.source        out_o
);

  logic      out_v_q;
  out_word_t out_q, out_d;

  function automatic logic [AMP_W-1:0] sat_q15(input logic [PROD_W-1:0] p);
    logic [AMP_W:0] s;
    s = p[PROD_W-1:SMP_W-1];
    return s[AMP_W] ? '1 : s[AMP_W-1:0];
  endfunction

  assign cap_o = ~out_v_q | out_o.ready;

  always_comb begin
    out_d.word_index_low  = meta_i.widx;
    out_d.amplitude_low   = sat_q15(prod_lo_i);
    out_d.word_index_high = {meta_i.widx[WIDX_W-1:1], 1'b1};
    out_d.amplitude_high  = sat_q15(prod_hi_i);
    out_d.last_out        = meta_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cap_o) begin
      out_v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_o) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/csam_checker.sv =====
// csam_checker: port-level checks of the amplitude map, bound to the top level.
// Depends on csam_pkg and current_steering_amplitude_map.
`default_nettype none

module csam_checker import csam_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result word changed while stalled");

  // slots are an even/odd pair of the same electrode pair
  a_slot_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.word_index_low[0] == 1'b0) &&
                    (out_data_i.word_index_high == out_data_i.word_index_low + 5'd1))
    else $error("word slot pair mismatch");

  // with the result register empty the pipeline always flows
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind current_steering_amplitude_map csam_checker u_csam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for current_steering_amplitude_map, carrier mode register
// plus electrode and channel table writes. Depends on csam_pkg, csam_in_if, csam_out_if.
module tb_top import csam_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH        = NUM_CHANNELS_DEF;
  localparam int N_EL        = NUM_ELECTRODES_DEF;
  localparam int AMP_MAX     = (1 << AMP_W) - 1;
  localparam int HOLD_CYCLES = 200;     // long output hold-off, fills the pipe
  localparam int SETTLE      = 12;      // longer than the pipeline latency, covers no-result words
  localparam int CYCLE_LIMIT = 500000;

  // codes the package has no member for
  localparam logic [REQ_W-1:0]  REQ_IGNORED = 2'd3;  // dropped, no result
  localparam logic [MODE_W-1:0] CM_UNUSED   = 2'd3;  // acts as no carrier

  typedef struct {
    in_word_t  word;
    bit        pinned;    // expected result typed in by hand
    out_word_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  csam_in_if  in_ch ();
  csam_out_if out_ch ();

  current_steering_amplitude_map dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // ---------------------------------------------------------------------------
  // Amplitude predictor: private copy of the tables and carrier mode.
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] gain_of_elec   [16];
  logic signed [COEF_W-1:0] offset_of_elec [16];
  logic [AMP_W-1:0]         clip_of_elec   [16];
  logic [IDX_W-1:0]         elec_of_chan   [16];
  logic [MODE_W-1:0]        mode_now;

  out_word_t pending_amps [$];   // expected result words, oldest first

  int err_cnt;
  int words_sent;
  int results_checked;
  int cycle_cnt;
  int maps_sent;

  // sink control, shared with the ready process
  bit sink_stalls;
  bit hold_req;
  int stall_left;

  out_word_t want_word;
  out_word_t got_word;

  // One electrode: gain*env (+offset), carrier per mode, clamp, weight, saturate.
  // All shifts are arithmetic, i.e. floor toward minus infinity.
  function automatic logic [AMP_W-1:0] steer_amp(input logic [IDX_W-1:0] el,
      input logic [SMP_W-1:0] env, input logic [SMP_W-1:0] car,
      input logic [SMP_W-1:0] wgt);
    longint g, k, clip, env_v, car_v, wgt_v, term, m, a;
    g     = longint'(gain_of_elec[el]);
    k     = longint'(offset_of_elec[el]);
    clip  = longint'(clip_of_elec[el]);
    env_v = longint'(env);
    car_v = longint'(car);
    wgt_v = longint'(wgt);
    term  = (g * env_v) >>> 15;
    case (mode_now)
      CM_ENV:  m = ((term * car_v) >>> 15) + k;
      CM_ALL:  m = ((term + k) * car_v) >>> 15;
      default: m = term + k;
    endcase
    if (m > clip) m = clip;
    if (m < 0) m = 0;
    a = (m * wgt_v) >>> 15;
    if (a > AMP_MAX) a = AMP_MAX;
    return a[AMP_W-1:0];
  endfunction

  // Applies one accepted word: table writes update state, a map on a valid
  // channel yields one result word.
  task automatic steer_step(input in_word_t w, output bit gives, output out_word_t res);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] el;
    gives = 1'b0;
    res   = '0;
    if (w.req_type == REQ_ELEC) begin
      if (w.index < N_EL) begin
        gain_of_elec[w.index]   = w.entry_gain;
        offset_of_elec[w.index] = w.entry_offset;
        clip_of_elec[w.index]   = w.entry_clip;
      end
    end else if (w.req_type == REQ_CHAN) begin
      if (w.index < N_CH) begin
        el = w.entry_electrode;
        if (el > N_EL - 2) el = IDX_W'(N_EL - 2);   // too-high low electrode saturates
        elec_of_chan[w.index] = el;
      end
    end else if (w.req_type == REQ_MAP && w.index < N_CH) begin
      lo = elec_of_chan[w.index];
      gives = 1'b1;
      res.word_index_low  = {lo, 1'b0};
      res.amplitude_low   = steer_amp(lo, w.envelope, w.carrier_sample, w.weight_low);
      res.word_index_high = {lo, 1'b1};
      res.amplitude_high  = steer_amp(lo + 4'd1, w.envelope, w.carrier_sample,
                                      w.weight_high);
      res.last_out        = w.frame_last;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Word builders. Fields a request does not use carry random junk.
  // ---------------------------------------------------------------------------
  function automatic in_word_t scramble_word();
    in_word_t w;
    w.req_type        = REQ_W'($urandom);
    w.index           = IDX_W'($urandom);
    w.envelope        = SMP_W'($urandom);
    w.carrier_sample  = SMP_W'($urandom);
    w.weight_low      = SMP_W'($urandom);
    w.weight_high     = SMP_W'($urandom);
    w.entry_gain      = COEF_W'($urandom);
    w.entry_offset    = COEF_W'($urandom);
    w.entry_clip      = AMP_W'($urandom);
    w.entry_electrode = IDX_W'($urandom);
    w.frame_last      = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t map_word(input int ch, input int env, input int car,
      input int wl, input int wh, input bit last);
    in_word_t w;
    w = scramble_word();
    w.req_type       = REQ_MAP;
    w.index          = ch[IDX_W-1:0];
    w.envelope       = env[SMP_W-1:0];
    w.carrier_sample = car[SMP_W-1:0];
    w.weight_low     = wl[SMP_W-1:0];
    w.weight_high    = wh[SMP_W-1:0];
    w.frame_last     = last;
    return w;
  endfunction

  function automatic in_word_t elec_word(input int el, input int g, input int k,
      input int clip);
    in_word_t w;
    w = scramble_word();
    w.req_type     = REQ_ELEC;
    w.index        = el[IDX_W-1:0];
    w.entry_gain   = g[COEF_W-1:0];
    w.entry_offset = k[COEF_W-1:0];
    w.entry_clip   = clip[AMP_W-1:0];
    return w;
  endfunction

  function automatic in_word_t chan_word(input int ch, input int el);
    in_word_t w;
    w = scramble_word();
    w.req_type        = REQ_CHAN;
    w.index           = ch[IDX_W-1:0];
    w.entry_electrode = el[IDX_W-1:0];
    return w;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w = scramble_word();
    w.req_type = REQ_IGNORED;
    return w;
  endfunction

  function automatic out_word_t known(input int wl, input int al, input int wh,
      input int ah, input bit last);
    out_word_t r;
    r.word_index_low  = wl[WIDX_W-1:0];
    r.amplitude_low   = al[AMP_W-1:0];
    r.word_index_high = wh[WIDX_W-1:0];
    r.amplitude_high  = ah[AMP_W-1:0];
    r.last_out        = last;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Q1.15 values: mostly 0..1.0, plus the edges and full 16-bit noise.
  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 65535);
      1:       return 0;
      2:       return 32768;
      3:       return 65535;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  // Q16.8 coefficients: mid-range values keep the clamp from always winning.
  function automatic int pick_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 8388607;
      2:       return -8388608;
      3:       return 0;
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 18);
    endcase
  endfunction

  function automatic int pick_clip();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return AMP_MAX;
      default: return $urandom_range(0, AMP_MAX);
    endcase
  endfunction

  // Random traffic: mostly maps on live channels, with table rewrites mixed in
  // and a little noise (dead channel, ignored request type).
  function automatic in_word_t gen_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 64)
      return map_word($urandom_range(0, N_CH - 1), pick_sample(), pick_sample(),
                      pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    if (r < 68)
      return map_word(15, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      1'($urandom_range(0, 1)));
    if (r < 82)
      return elec_word($urandom_range(0, 15), pick_coef(), pick_coef(), pick_clip());
    if (r < 92)
      return chan_word($urandom_range(0, 15), $urandom_range(0, 15));
    return noise_word();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Data changes at the falling edge, acceptance is seen at the
  // rising edge. valid stays high between back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input int gap, input bit pinned,
      input out_word_t pinned_res);
    bit        gives;
    out_word_t pred;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    steer_step(w, gives, pred);
    if (gives) begin
      pending_amps.push_back(pinned ? pinned_res : pred);
      maps_sent++;
    end
    words_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sender goes quiet until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_amps.size() != 0) @(posedge clk);
  endtask

  // Mode write only on an idle block; the extra settle covers words still in
  // the pipe that will never produce a result (dead channel, writes, noise).
  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    mode_now   = m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] m, input int count,
      input bit snd_idle, input bit snk_idle, input bit with_hold);
    int burst;
    burst = 0;
    write_mode(m);
    sink_stalls = snk_idle;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) drain_results();
      if (with_hold && i == count / 2) begin
        hold_req = 1'b1;
        burst    = 40;     // keep offering while the sink is held off
      end
      if (burst > 0) begin
        burst--;
        send_word(gen_word(), 0, 1'b0, '0);
      end else begin
        send_word(gen_word(), snd_idle ? pick_gap() : 0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string what, input int unsigned want,
      input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_word = out_ch.data;
      if (pending_amps.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result word with none expected, expected nothing, actual %h",
                 $time, got_word);
      end else begin
        want_word = pending_amps.pop_front();
        check_field("word_index_low", 32'(want_word.word_index_low),
                    32'(got_word.word_index_low));
        check_field("amplitude_low", 32'(want_word.amplitude_low),
                    32'(got_word.amplitude_low));
        check_field("word_index_high", 32'(want_word.word_index_high),
                    32'(got_word.word_index_high));
        check_field("amplitude_high", 32'(want_word.amplitude_high),
                    32'(got_word.amplitude_high));
        check_field("last_out", 32'(want_word.last_out), 32'(got_word.last_out));
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still outstanding", $time,
               pending_amps.size());
      $display("** current_steering_amplitude_map: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [$];

  task automatic add_row(input in_word_t w, input bit pinned, input out_word_t res);
    stim_row_t r;
    r.word   = w;
    r.pinned = pinned;
    r.res    = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    sink_stalls = 1'b1;
    hold_req    = 1'b0;
    err_cnt     = 0;
    words_sent  = 0;
    maps_sent   = 0;
    results_checked = 0;
    cycle_cnt   = 0;
    mode_now    = CM_NONE;
    for (int i = 0; i < 16; i++) begin
      gain_of_elec[i]   = '0;
      offset_of_elec[i] = '0;
      clip_of_elec[i]   = '0;
      elec_of_chan[i]   = '0;
    end

    // Directed: reset state, table and field extremes, dead channel, ignored
    // request, electrode saturation, weight overflow. Mode stays at reset.
    // Zero tables: every map comes back as slots 0/1 with zero amplitude.
    add_row(map_word(0, 65535, 65535, 65535, 65535, 1), 1, known(0, 0, 1, 0, 1));
    add_row(map_word(14, 0, 0, 0, 0, 0), 1, known(0, 0, 1, 0, 0));
    add_row(map_word(15, 32768, 32768, 32768, 32768, 1), 0, '0);
    add_row(noise_word(), 0, '0);
    // electrode 0 gain 1.0, electrode 1 gain/offset at the top: clip wins
    add_row(elec_word(0, 256, 0, AMP_MAX), 0, '0);
    add_row(elec_word(1, 8388607, 8388607, AMP_MAX), 0, '0);
    add_row(map_word(0, 32768, 0, 32768, 32768, 0), 1, known(0, 256, 1, AMP_MAX, 0));
    // weight just under 2.0: low doubles, high overflows 20 bits and saturates
    add_row(map_word(0, 32768, 65535, 65535, 65535, 1), 1, known(0, 511, 1, AMP_MAX, 1));
    add_row(elec_word(15, -8388608, -8388608, 0), 0, '0);
    add_row(elec_word(14, -256, 8388607, 1000), 0, '0);
    // low electrode 15 is stored as 14, so channel 0 now steers 14/15
    add_row(chan_word(0, 15), 0, '0);
    add_row(map_word(0, 0, 32768, 32768, 32768, 1), 1, known(28, 1000, 29, 0, 1));
    add_row(map_word(0, 32768, 0, 32768, 65535, 0), 0, '0);
    add_row(chan_word(15, 3), 0, '0);          // dead channel, write dropped
    add_row(map_word(15, 12345, 32768, 32768, 32768, 1), 0, '0);
    add_row(chan_word(14, 1), 0, '0);
    add_row(elec_word(2, 384, -512, 2048), 0, '0);
    add_row(map_word(14, 16384, 16384, 20000, 32768, 1), 0, '0);
    add_row(map_word(14, 777, 9999, 32768, 32768, 0), 0, '0);
    add_row(elec_word(1, -12345, 4096, 65536), 0, '0);
    add_row(map_word(14, 40000, 65535, 32767, 49152, 1), 0, '0);
    add_row(chan_word(3, 13), 0, '0);
    add_row(map_word(3, 30000, 2, 65535, 1, 0), 0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, pick_gap(), dir_rows[i].pinned, dir_rows[i].res);

    // Random phases, one carrier mode each; idling on or off per side.
    //        mode       words idle-in idle-out hold-off
    run_phase(CM_ENV,    155,  1,      1,       0);
    run_phase(CM_ALL,    155,  0,      1,       1);
    run_phase(CM_UNUSED, 155,  1,      0,       0);
    run_phase(CM_NONE,   155,  0,      0,       0);
    run_phase(CM_ALL,    155,  1,      1,       0);
    run_phase(CM_ENV,    155,  1,      1,       0);

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d input words, %0d of them maps, %0d result words checked,",
             words_sent, maps_sent, results_checked);
    $display("over carrier modes 0-3, table rewrites, dropped requests and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("** current_steering_amplitude_map: PASSED **");
    end else begin
      $display("** current_steering_amplitude_map: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csam_pkg.sv
rtl/csam_in_if.sv
rtl/csam_out_if.sv
rtl/csam_etab.sv
rtl/csam_lane.sv
rtl/csam_merge.sv
rtl/current_steering_amplitude_map.sv
rtl/csam_checker.sv
bench/tb_top.sv
